// ===== hw/rtl/floor_divider_with_flags_top_assert.svh =====
// ============================================================================
// Floor divider assertion macros
// Shared concurrent assertion forms for the floor divider.
// ============================================================================
`ifndef FLOOR_DIVIDER_WITH_FLAGS_TOP_ASSERT_SVH
`define FLOOR_DIVIDER_WITH_FLAGS_TOP_ASSERT_SVH

// same-cycle implication
`define FDWF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("floor divider assertion failed");

// next-cycle implication
`define FDWF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("floor divider assertion failed");

`endif

// ===== hw/rtl/fdwf_pkg.sv =====
// ============================================================================
// Floor divider package
// Shared constants and the control bundle that travels down the pipeline.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package fdwf_pkg;

   localparam int DATA_BITS     = 32;
   localparam int WIDTH_DEFAULT = 32;

   typedef struct packed {
      logic neg;
      logic dbz;
      logic ovf;
      logic last;
   } ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/floor_divider_with_flags_top.sv =====
// ============================================================================
// Floor divider with flags
// Pipelined signed floor / unsigned divider with zero and overflow flags.
// ============================================================================
// Takes one request per cycle while req_stall is low and returns one response
// per request, in order. It has one operand stage, one restoring division stage
// per quotient bit, and one correction/output stage. Each stage holds its
// request under stall and fills bubbles, so requests keep entering while a
// finished response waits, until every stage is full. csr_write_data[0] selects
// signed floor division (1, reset value) or unsigned division (0); write it only
// while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none

`include "floor_divider_with_flags_top_assert.svh"

module floor_divider_with_flags_top #(
   parameter int WIDTH = fdwf_pkg::WIDTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_enable,
   input  wire logic                           csr_write_data,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [fdwf_pkg::DATA_BITS-1:0] req_dividend,
   input  wire logic [fdwf_pkg::DATA_BITS-1:0] req_divisor,
   input  wire logic                           req_last_element,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [fdwf_pkg::DATA_BITS-1:0]      rsp_quotient,
   output logic                                rsp_divide_by_zero,
   output logic                                rsp_overflowed,
   output logic                                rsp_last_out
);

   logic               signed_mode_ff;
   logic               signed_mode_in;

   logic               st_valid [0:WIDTH];
   logic               st_stall [0:WIDTH];
   logic [WIDTH-1:0]   st_rem   [0:WIDTH];
   logic [WIDTH-1:0]   st_quo   [0:WIDTH];
   logic [WIDTH-1:0]   st_div   [0:WIDTH];
   fdwf_pkg::ctrl_type st_ctrl  [0:WIDTH];

   assign signed_mode_in = csr_write_enable ? csr_write_data : signed_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff <= 1'b1;
      end else begin
         signed_mode_ff <= signed_mode_in;
      end
   end

   fdwf_prep #(.WIDTH(WIDTH)) u_prep (
      .clock       (clock),
      .reset       (reset),
      .signed_mode (signed_mode_ff),
      .in_valid    (req_valid),
      .in_stall    (req_stall),
      .in_dividend (req_dividend),
      .in_divisor  (req_divisor),
      .in_last     (req_last_element),
      .out_valid   (st_valid[0]),
      .out_stall   (st_stall[0]),
      .out_quo     (st_quo[0]),
      .out_div     (st_div[0]),
      .out_ctrl    (st_ctrl[0])
   );

   assign st_rem[0] = '0;

   for (genvar i = 0; i < WIDTH; i++) begin : g_step
      fdwf_step #(.WIDTH(WIDTH)) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (st_valid[i]),
         .in_stall  (st_stall[i]),
         .in_rem    (st_rem[i]),
         .in_quo    (st_quo[i]),
         .in_div    (st_div[i]),
         .in_ctrl   (st_ctrl[i]),
         .out_valid (st_valid[i+1]),
         .out_stall (st_stall[i+1]),
         .out_rem   (st_rem[i+1]),
         .out_quo   (st_quo[i+1]),
         .out_div   (st_div[i+1]),
         .out_ctrl  (st_ctrl[i+1])
      );
   end

   fdwf_fix #(.WIDTH(WIDTH)) u_fix (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (st_valid[WIDTH]),
      .in_stall           (st_stall[WIDTH]),
      .in_rem             (st_rem[WIDTH]),
      .in_quo             (st_quo[WIDTH]),
      .in_ctrl            (st_ctrl[WIDTH]),
      .out_valid          (rsp_valid),
      .out_stall          (rsp_stall),
      .out_quotient       (rsp_quotient),
      .out_divide_by_zero (rsp_divide_by_zero),
      .out_overflowed     (rsp_overflowed),
      .out_last           (rsp_last_out)
   );

   // divisor out of the last step is never read by the fix stage; keep it tied off
   logic unused_div;
   assign unused_div = ^st_div[WIDTH];

   `FDWF_ASSERT_NOW(a_dbz_zero, clock, reset, rsp_valid && rsp_divide_by_zero, rsp_quotient == '0)
   `FDWF_ASSERT_NOW(a_flags_excl, clock, reset, rsp_valid, !(rsp_divide_by_zero && rsp_overflowed))
   `FDWF_ASSERT_NOW(a_empty_no_stall, clock, reset, !rsp_valid, !req_stall)

endmodule

`default_nettype wire

// ===== hw/rtl/fdwf_prep.sv =====
// ============================================================================
// Floor divider operand stage
// Decodes signs, takes magnitudes and flags the special cases.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fdwf_prep #(
   parameter int WIDTH = fdwf_pkg::WIDTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           signed_mode,
   input  wire logic                           in_valid,
   output logic                                in_stall,
   input  wire logic [fdwf_pkg::DATA_BITS-1:0] in_dividend,
   input  wire logic [fdwf_pkg::DATA_BITS-1:0] in_divisor,
   input  wire logic                           in_last,
   output logic                                out_valid,
   input  wire logic                           out_stall,
   output logic [WIDTH-1:0]                    out_quo,
   output logic [WIDTH-1:0]                    out_div,
   output fdwf_pkg::ctrl_type                  out_ctrl
);

   localparam logic [WIDTH-1:0] SIGN_BIT = {1'b1, {(WIDTH-1){1'b0}}};

   logic [WIDTH-1:0]   a;
   logic [WIDTH-1:0]   b;
   logic               na;
   logic               nb;
   logic               load;
   logic               valid_ff;
   logic               valid_in;
   logic [WIDTH-1:0]   quo_ff;
   logic [WIDTH-1:0]   quo_in;
   logic [WIDTH-1:0]   div_ff;
   logic [WIDTH-1:0]   div_in;
   fdwf_pkg::ctrl_type ctrl_ff;
   fdwf_pkg::ctrl_type ctrl_in;

   assign in_stall = valid_ff & out_stall;
   assign load     = in_valid & ~in_stall;

   always_comb begin
      a            = WIDTH'(in_dividend);
      b            = WIDTH'(in_divisor);
      na           = signed_mode & a[WIDTH-1];
      nb           = signed_mode & b[WIDTH-1];
      quo_in       = na ? ('0 - a) : a;
      div_in       = nb ? ('0 - b) : b;
      ctrl_in.neg  = na ^ nb;
      ctrl_in.dbz  = (b == '0);
      ctrl_in.ovf  = signed_mode & (a == SIGN_BIT) & (b == '1);
      ctrl_in.last = in_last;
      valid_in     = in_stall ? valid_ff : in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         quo_ff  <= quo_in;
         div_ff  <= div_in;
         ctrl_ff <= ctrl_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_quo   = quo_ff;
   assign out_div   = div_ff;
   assign out_ctrl  = ctrl_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fdwf_step.sv =====
// ============================================================================
// Floor divider step stage
// One restoring division step: one quotient bit per stage.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fdwf_step #(
   parameter int WIDTH = fdwf_pkg::WIDTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_stall,
   input  wire logic [WIDTH-1:0]   in_rem,
   input  wire logic [WIDTH-1:0]   in_quo,
   input  wire logic [WIDTH-1:0]   in_div,
   input  wire fdwf_pkg::ctrl_type in_ctrl,
   output logic                    out_valid,
   input  wire logic               out_stall,
   output logic [WIDTH-1:0]        out_rem,
   output logic [WIDTH-1:0]        out_quo,
   output logic [WIDTH-1:0]        out_div,
   output fdwf_pkg::ctrl_type      out_ctrl
);

   logic [WIDTH:0]     partial;
   logic [WIDTH:0]     diff;
   logic               fits;
   logic               load;
   logic               valid_ff;
   logic               valid_in;
   logic [WIDTH-1:0]   rem_ff;
   logic [WIDTH-1:0]   rem_in;
   logic [WIDTH-1:0]   quo_ff;
   logic [WIDTH-1:0]   quo_in;
   logic [WIDTH-1:0]   div_ff;
   fdwf_pkg::ctrl_type ctrl_ff;

   assign in_stall = valid_ff & out_stall;
   assign load     = in_valid & ~in_stall;

   always_comb begin
      partial  = {in_rem, in_quo[WIDTH-1]};
      diff     = partial - {1'b0, in_div};
      fits     = ~diff[WIDTH];
      rem_in   = fits ? diff[WIDTH-1:0] : partial[WIDTH-1:0];
      quo_in   = {in_quo[WIDTH-2:0], fits};
      valid_in = in_stall ? valid_ff : in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         div_ff  <= in_div;
         ctrl_ff <= in_ctrl;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_div   = div_ff;
   assign out_ctrl  = ctrl_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fdwf_fix.sv =====
// ============================================================================
// Floor divider result stage
// Applies sign and floor correction, special cases, and holds the response.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fdwf_fix #(
   parameter int WIDTH = fdwf_pkg::WIDTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   output logic                                in_stall,
   input  wire logic [WIDTH-1:0]               in_rem,
   input  wire logic [WIDTH-1:0]               in_quo,
   input  wire fdwf_pkg::ctrl_type             in_ctrl,
   output logic                                out_valid,
   input  wire logic                           out_stall,
   output logic [fdwf_pkg::DATA_BITS-1:0]      out_quotient,
   output logic                                out_divide_by_zero,
   output logic                                out_overflowed,
   output logic                                out_last
);

   localparam logic [WIDTH-1:0] SIGN_BIT = {1'b1, {(WIDTH-1){1'b0}}};

   logic                               load;
   logic                               valid_ff;
   logic                               valid_in;
   logic [WIDTH-1:0]                   q;
   logic [fdwf_pkg::DATA_BITS-1:0]     quotient_ff;
   logic [fdwf_pkg::DATA_BITS-1:0]     quotient_in;
   logic                               dbz_ff;
   logic                               ovf_ff;
   logic                               last_ff;

   assign in_stall = valid_ff & out_stall;
   assign load     = in_valid & ~in_stall;

   // floor: -q when exact, -q-1 (= ~q) otherwise
   always_comb begin
      if (in_ctrl.dbz) begin
         q = '0;
      end else if (in_ctrl.ovf) begin
         q = SIGN_BIT;
      end else if (in_ctrl.neg) begin
         q = (in_rem != '0) ? ~in_quo : ('0 - in_quo);
      end else begin
         q = in_quo;
      end
      quotient_in = fdwf_pkg::DATA_BITS'(q);
      valid_in    = in_stall ? valid_ff : in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         quotient_ff <= quotient_in;
         dbz_ff      <= in_ctrl.dbz;
         ovf_ff      <= in_ctrl.ovf & ~in_ctrl.dbz;
         last_ff     <= in_ctrl.last;
      end
   end

   assign out_valid          = valid_ff;
   assign out_quotient       = quotient_ff;
   assign out_divide_by_zero = dbz_ff;
   assign out_overflowed     = ovf_ff;
   assign out_last           = last_ff;

endmodule

`default_nettype wire
